@@ rtl/kwm_pkg.sv @@
// Shared types and constants for the k-way merge engine.
// No dependencies; imported by the top level, kway_merge_engine_core.
package kwm_pkg;

  localparam int KEY_W      = 64;
  localparam int SRC_W      = 4;
  localparam int CNT_REG_W  = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CNT_REG_W-1:0] SOURCE_COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } kwm_state_t;

endpackage

@@ rtl/kway_merge_engine_core.sv @@
// K-way merge engine top level; depends on kwm_pkg and kwm_head_ram.
// An applied transfer moves the engine from idle to a scan of the head memory, one
// entry per cycle over the active sources (at most 16 entries), then to emit, which
// registers the result; in_stall is high until then, longer under out_stall. Priming
// items before the last and dropped items leave it in idle. Synchronous reset clears control
// state, restores source_count to 16 and leaves head keys undefined behind valid bits.
module kway_merge_engine_core #(
  parameter int MAX_SOURCES = 16,
  parameter int KEY_BITS    = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kwm_pkg::SRC_W-1:0]        in_source_index,
  input  logic [kwm_pkg::KEY_W-1:0]        in_record_key,
  input  logic                             in_stream_end,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kwm_pkg::KEY_W-1:0]        out_key,
  output logic [kwm_pkg::SRC_W-1:0]        out_source,
  output logic                             out_done_res,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [kwm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [kwm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [kwm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import kwm_pkg::*;

  localparam int HEAD_DEPTH = (MAX_SOURCES < (1 << SRC_W)) ? MAX_SOURCES : (1 << SRC_W);
  localparam int IDX_W      = $clog2(HEAD_DEPTH);
  localparam int CNT_W      = $clog2(HEAD_DEPTH + 1);

  kwm_state_t state_r, state_nxt;

  logic [CNT_REG_W-1:0]  source_count_r;
  logic [HEAD_DEPTH-1:0] valid_r, valid_nxt;
  logic [CNT_REG_W-1:0]  primed_r, primed_nxt;
  logic [SRC_W-1:0]      awaited_r, awaited_nxt;
  logic                  finished_r, finished_nxt;
  logic [CNT_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  found_r, found_nxt;
  logic [KEY_BITS-1:0]   best_key_r, best_key_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]      out_key_r, out_key_nxt;
  logic [SRC_W-1:0]      out_source_r, out_source_nxt;
  logic                  out_done_r, out_done_nxt;

  logic                  cfg_wr;
  logic [CNT_REG_W-1:0]  count_nz;
  logic [CNT_REG_W-1:0]  active_n;
  logic [CNT_W-1:0]      scan_lim;
  logic                  in_xfer;
  logic                  priming;
  logic                  apply;
  logic [CNT_REG_W-1:0]  src_ext;
  logic [IDX_W-1:0]      src_idx;

  logic                  ram_wr_en;
  logic                  ram_rd_en;
  logic [IDX_W-1:0]      ram_rd_addr;
  logic [KEY_BITS-1:0]   ram_rd_data;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {{(CFG_DATA_W-CNT_REG_W){1'b0}}, source_count_r};

  assign count_nz = (source_count_r == '0) ? CNT_REG_W'(1) : source_count_r;
  assign active_n = (32'(count_nz) > MAX_SOURCES) ? CNT_REG_W'(MAX_SOURCES) : count_nz;
  assign scan_lim = (32'(active_n) > HEAD_DEPTH) ? CNT_W'(HEAD_DEPTH) : CNT_W'(active_n);

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign src_ext  = CNT_REG_W'(in_source_index);
  assign src_idx  = in_source_index[IDX_W-1:0];
  assign priming  = (primed_r < active_n);
  assign apply    = in_xfer && !finished_r &&
                    (priming ? ((src_ext == primed_r) && (32'(in_source_index) < MAX_SOURCES))
                             : ((in_source_index == awaited_r) && (src_ext < active_n)));
  assign ram_wr_en = apply && !in_stream_end;

  kwm_head_ram #(
    .DEPTH (HEAD_DEPTH),
    .WIDTH (KEY_BITS)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (src_idx),
    .wr_data (in_record_key[KEY_BITS-1:0]),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    primed_nxt     = primed_r;
    awaited_nxt    = awaited_r;
    finished_nxt   = finished_r;
    scan_idx_nxt   = scan_idx_r;
    rd_pend_nxt    = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    best_key_nxt   = best_key_r;
    best_idx_nxt   = best_idx_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_key_nxt    = out_key_r;
    out_source_nxt = out_source_r;
    out_done_nxt   = out_done_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = scan_idx_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (apply) begin
          valid_nxt[src_idx] = !in_stream_end;
          if (priming) begin
            primed_nxt = primed_r + CNT_REG_W'(1);
          end
          if (!priming || (primed_r + CNT_REG_W'(1) == active_n)) begin
            state_nxt    = ST_SCAN;
            scan_idx_nxt = '0;
            found_nxt    = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx_r < scan_lim) begin
          ram_rd_en    = 1'b1;
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end else if (!rd_pend_r) begin
          state_nxt = ST_EMIT;
        end
        if (rd_pend_r && valid_r[rd_idx_r] && (!found_r || (ram_rd_data < best_key_r))) begin
          found_nxt    = 1'b1;
          best_key_nxt = ram_rd_data;
          best_idx_nxt = rd_idx_r;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (found_r) begin
            out_key_nxt           = KEY_W'(best_key_r);
            out_source_nxt        = SRC_W'(best_idx_r);
            out_done_nxt          = 1'b0;
            valid_nxt[best_idx_r] = 1'b0;
            awaited_nxt           = SRC_W'(best_idx_r);
          end else begin
            out_key_nxt    = '0;
            out_source_nxt = '0;
            out_done_nxt   = 1'b1;
            finished_nxt   = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      state_nxt    = ST_IDLE;
      valid_nxt    = '0;
      primed_nxt   = '0;
      awaited_nxt  = '0;
      finished_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      source_count_r <= SOURCE_COUNT_RESET;
      valid_r        <= '0;
      primed_r       <= '0;
      awaited_r      <= '0;
      finished_r     <= 1'b0;
      rd_pend_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      primed_r    <= primed_nxt;
      awaited_r   <= awaited_nxt;
      finished_r  <= finished_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        source_count_r <= cfg_pwdata[CNT_REG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    found_r      <= found_nxt;
    best_key_r   <= best_key_nxt;
    best_idx_r   <= best_idx_nxt;
    out_key_r    <= out_key_nxt;
    out_source_r <= out_source_nxt;
    out_done_r   <= out_done_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_key      = out_key_r;
  assign out_source   = out_source_r;
  assign out_done_res = out_done_r;

  // cfg_paddr is unused; there is a single register word
  logic unused_addr;
  assign unused_addr = ^cfg_paddr;

endmodule

@@ rtl/kwm_head_ram.sv @@
// Head-key memory: one write port, one read port, registered read data.
// Uses kwm_pkg only through the top level; no package items needed here.
module kwm_head_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
